// ----- hw/rtl/gstp_pkg.sv -----
// Shared types, constants and fixed-point helpers for the gas thermo pipeline.
// Q31.32 saturating add, subtract and multiply rounding; constants are
// worked out at elaboration. No dependencies.
package gstp_pkg;

  typedef logic signed [63:0] q_t;

  localparam q_t Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_MIN  = 64'sh8000_0000_0000_0000;
  localparam q_t Q_TR   = 64'sd1280544499302;
  localparam q_t Q_CAL  = 64'sd17970143166;
  localparam q_t Q_LN2  = 64'sd2977044472;

  localparam int unsigned L_MUL     = 3;
  localparam int unsigned RCP_STEPS = 65;
  localparam int unsigned L_RCP     = RCP_STEPS + 1;
  localparam int unsigned LOG_BITS  = 32;
  localparam int unsigned L_LOG     = 2 + 2 * LOG_BITS + L_MUL + 1;

  localparam logic [2:0] REG_GF   = 3'd0;
  localparam logic [2:0] REG_HF   = 3'd1;
  localparam logic [2:0] REG_SR   = 3'd2;
  localparam logic [2:0] REG_A    = 3'd3;
  localparam logic [2:0] REG_B    = 3'd4;
  localparam logic [2:0] REG_C    = 3'd5;
  localparam logic [2:0] REG_TMAX = 3'd6;

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) qadd = s[64] ? Q_MIN : Q_MAX;
    else qadd = s[63:0];
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) qsub = s[64] ? Q_MIN : Q_MAX;
    else qsub = s[63:0];
  endfunction

  // p is the magnitude product plus the rounding half
  function automatic q_t qmul_fin(input logic [127:0] p, input logic neg);
    logic [63:0] mag;
    mag = p[95:32];
    if (p[127:96] != 32'd0) qmul_fin = neg ? Q_MIN : Q_MAX;
    else if (neg) qmul_fin = mag[63] ? Q_MIN : q_t'(~mag + 64'd1);
    else qmul_fin = mag[63] ? Q_MAX : q_t'(mag);
  endfunction

  function automatic q_t half_q(input q_t x);
    logic [63:0] u;
    logic [63:0] mag;
    u = x[63] ? (~x + 64'd1) : x;
    mag = (u + 64'd1) >> 1;
    half_q = x[63] ? q_t'(~mag + 64'd1) : q_t'(mag);
  endfunction

  function automatic q_t qmul_c(input q_t a, input q_t b);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [127:0] p;
    ua = a[63] ? (~a + 64'd1) : a;
    ub = b[63] ? (~b + 64'd1) : b;
    p = {64'd0, ua} * {64'd0, ub} + 128'h8000_0000;
    qmul_c = qmul_fin(p, a[63] ^ b[63]);
  endfunction

  function automatic q_t recip_c(input logic [63:0] d);
    logic [64:0] part;
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int j = 0; j < RCP_STEPS; j++) begin
      part = {r, (j == 0) ? 1'b1 : 1'b0};
      if (part >= {1'b0, d}) begin
        r = 64'(part - {1'b0, d});
        q = {q[62:0], 1'b1};
      end else begin
        r = part[63:0];
        q = {q[62:0], 1'b0};
      end
    end
    if (d <= 64'd2) recip_c = Q_MAX;
    else if ({r, 1'b0} >= {1'b0, d}) recip_c = q_t'(q + 64'd1);
    else recip_c = q_t'(q);
  endfunction

  function automatic q_t ln_c(input logic [63:0] x);
    int n;
    logic [63:0] m;
    logic [127:0] sq;
    logic [31:0] f;
    n = 0;
    for (int i = 0; i < 64; i++) if (x[i]) n = i;
    m = x << (63 - n);
    f = '0;
    for (int i = 0; i < LOG_BITS; i++) begin
      sq = {64'd0, m} * {64'd0, m};
      if (sq[127]) begin
        m = sq[127:64];
        f = {f[30:0], 1'b1};
      end else begin
        m = sq[126:63];
        f = {f[30:0], 1'b0};
      end
    end
    ln_c = qmul_c({32'(n - 32), f}, Q_LN2);
  endfunction

  localparam q_t TR2     = qmul_c(Q_TR, Q_TR);
  localparam q_t INV_TR  = recip_c(Q_TR);
  localparam q_t INV_TR2 = recip_c(TR2);
  localparam q_t LN_TR   = ln_c(Q_TR);

endpackage

// ----- hw/rtl/gstp_delay.sv -----
// Enabled delay line of fixed depth for payload alignment.
// No package dependency.
module gstp_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  if (D == 0) begin : g_thru
    assign q_o = d_i;
  end else begin : g_line
    logic [W-1:0] pipe_q [D];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pipe_q[0] <= d_i;
        for (int k = 1; k < D; k++) pipe_q[k] <= pipe_q[k-1];
      end
    end
    assign q_o = pipe_q[D-1];
  end

endmodule

// ----- hw/rtl/gstp_qmul.sv -----
// Pipelined Q31.32 multiply, round half away from zero, saturate.
// Depends on gstp_pkg.
module gstp_qmul (
  input  logic             clk_i,
  input  logic             en_i,
  input  gstp_pkg::q_t     a_i,
  input  gstp_pkg::q_t     b_i,
  output gstp_pkg::q_t     q_o
);
  import gstp_pkg::*;

  logic [63:0] ua_q, ub_q;
  logic        neg1_q, neg2_q;
  logic [63:0] ll_q, lh_q, hl_q, hh_q;
  logic [127:0] p;

  assign p = {hh_q, 64'd0} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0}
           + {64'd0, ll_q} + 128'h8000_0000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= a_i[63] ? (~a_i + 64'd1) : a_i;
      ub_q   <= b_i[63] ? (~b_i + 64'd1) : b_i;
      neg1_q <= a_i[63] ^ b_i[63];
      ll_q   <= {32'd0, ua_q[31:0]} * {32'd0, ub_q[31:0]};
      lh_q   <= {32'd0, ua_q[31:0]} * {32'd0, ub_q[63:32]};
      hl_q   <= {32'd0, ua_q[63:32]} * {32'd0, ub_q[31:0]};
      hh_q   <= {32'd0, ua_q[63:32]} * {32'd0, ub_q[63:32]};
      neg2_q <= neg1_q;
      q_o    <= qmul_fin(p, neg2_q);
    end
  end

endmodule

// ----- hw/rtl/gstp_recip.sv -----
// Pipelined round(2^64/d), one restoring quotient bit per stage, saturated.
// Depends on gstp_pkg.
module gstp_recip (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  d_i,
  output gstp_pkg::q_t q_o
);
  import gstp_pkg::*;

  logic [63:0] rem_q [RCP_STEPS];
  logic [63:0] quo_q [RCP_STEPS];
  logic [63:0] den_q [RCP_STEPS];

  for (genvar j = 0; j < RCP_STEPS; j++) begin : g_step
    logic [63:0] rin, qin, din;
    logic [64:0] part;
    if (j == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign din = d_i;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign qin = quo_q[j-1];
      assign din = den_q[j-1];
    end
    assign part = {rin, (j == 0) ? 1'b1 : 1'b0};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (part >= {1'b0, din}) begin
          rem_q[j] <= 64'(part - {1'b0, din});
          quo_q[j] <= {qin[62:0], 1'b1};
        end else begin
          rem_q[j] <= part[63:0];
          quo_q[j] <= {qin[62:0], 1'b0};
        end
        den_q[j] <= din;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (den_q[RCP_STEPS-1] <= 64'd2) q_o <= Q_MAX;
      else if ({rem_q[RCP_STEPS-1], 1'b0} >= {1'b0, den_q[RCP_STEPS-1]})
        q_o <= q_t'(quo_q[RCP_STEPS-1] + 64'd1);
      else q_o <= q_t'(quo_q[RCP_STEPS-1]);
    end
  end

endmodule

// ----- hw/rtl/gstp_log.sv -----
// Pipelined ln(T/Tr): normalize, square the mantissa once per bit, scale by ln2.
// Depends on gstp_pkg and gstp_qmul.
module gstp_log (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [27:0]  t_i,
  output gstp_pkg::q_t lnr_o
);
  import gstp_pkg::*;

  logic [27:0] t_q;
  logic [4:0]  nt, nt_q;
  logic [63:0] m0_q;
  logic signed [5:0] e0_q;

  logic [63:0] ll_q [LOG_BITS];
  logic [63:0] lh_q [LOG_BITS];
  logic [63:0] hh_q [LOG_BITS];
  logic [LOG_BITS-1:0] fa_q [LOG_BITS];
  logic signed [5:0]   ea_q [LOG_BITS];
  logic [63:0] m_q [LOG_BITS];
  logic [LOG_BITS-1:0] f_q [LOG_BITS];
  logic signed [5:0]   e_q [LOG_BITS];

  q_t ln2v, ln_t;

  always_comb begin
    nt = '0;
    for (int i = 0; i < 28; i++) if (t_i[i]) nt = 5'(i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= t_i;
      nt_q <= nt;
      m0_q <= {t_q, 36'd0} << (5'd27 - nt_q);
      e0_q <= 6'(signed'({1'b0, nt_q}) - 6'sd16);
    end
  end

  for (genvar j = 0; j < LOG_BITS; j++) begin : g_sq
    logic [63:0] min;
    logic [LOG_BITS-1:0] fin;
    logic signed [5:0]   ein;
    logic [127:0] sq;
    if (j == 0) begin : g_first
      assign min = m0_q;
      assign fin = '0;
      assign ein = e0_q;
    end else begin : g_next
      assign min = m_q[j-1];
      assign fin = f_q[j-1];
      assign ein = e_q[j-1];
    end
    assign sq = {hh_q[j], 64'd0} + {31'd0, lh_q[j], 33'd0} + {64'd0, ll_q[j]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ll_q[j] <= {32'd0, min[31:0]} * {32'd0, min[31:0]};
        lh_q[j] <= {32'd0, min[31:0]} * {32'd0, min[63:32]};
        hh_q[j] <= {32'd0, min[63:32]} * {32'd0, min[63:32]};
        fa_q[j] <= fin;
        ea_q[j] <= ein;
        if (sq[127]) begin
          m_q[j] <= sq[127:64];
          f_q[j] <= {fa_q[j][LOG_BITS-2:0], 1'b1};
        end else begin
          m_q[j] <= sq[126:63];
          f_q[j] <= {fa_q[j][LOG_BITS-2:0], 1'b0};
        end
        e_q[j] <= ea_q[j];
      end
    end
  end

  assign ln2v = {{(64 - LOG_BITS - 6){e_q[LOG_BITS-1][5]}}, e_q[LOG_BITS-1],
                 f_q[LOG_BITS-1]};

  gstp_qmul u_ln2 (.clk_i, .en_i, .a_i(ln2v), .b_i(Q_LN2), .q_o(ln_t));

  always_ff @(posedge clk_i) begin
    if (en_i) lnr_o <= qsub(ln_t, LN_TR);
  end

endmodule

// ----- hw/rtl/gas_standard_thermo_properties.sv -----
// Standard thermodynamic properties of a gas species from Maier-Kelley
// heat-capacity coefficients; top level. Depends on gstp_pkg, gstp_delay,
// gstp_qmul, gstp_recip and gstp_log.
//
// Usage:
//   Program the seven registers over the APB port while no item is in flight
//   (64-bit registers at byte address 8*i, max_temperature keeps 28 bits).
//   Send temperatures (Q12.16 kelvin, s_tdata[27:0]) on the slave stream.
//   Each item yields one result on the master stream: six Q31.32 fields in
//   m_tdata and the out-of-range flag in m_tuser.
//   Each item passes through the log front end (two stages per squaring
//   bit) and then the multiply and sum stages before m_tvalid rises.
//   Throughput is one item per cycle while m_tready does not stall the output.
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
//   Reset clears the registers to zero and empties the pipeline.
module gas_standard_thermo_properties (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [27:0] temperature
  output logic         m_tvalid,
  input  logic         m_tready,
  // [63:0] gibbs, [127:64] enthalpy, [191:128] entropy,
  // [255:192] enthalpy again, [319:256] helmholtz, [383:320] heat_capacity
  output logic [383:0] m_tdata,
  output logic [0:0]   m_tuser,   // [0] out_of_range
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import gstp_pkg::*;

  localparam int unsigned L_FRONT = (L_RCP > L_LOG) ? L_RCP : L_LOG;
  localparam int unsigned S_B   = L_FRONT + 1;
  localparam int unsigned S_C   = S_B + L_MUL;
  localparam int unsigned S_D   = S_C + 1;
  localparam int unsigned S_E   = S_D + 1;
  localparam int unsigned S_F   = S_E + 1;
  localparam int unsigned S_G   = S_F + L_MUL;
  localparam int unsigned S_H   = S_G + 1;
  localparam int unsigned S_OUT = S_H + L_MUL;

  q_t gf_q, hf_q, sr_q, a_q, b_q, c_q, hb_q, hc_q;
  logic [27:0] tmax_q;
  logic        wr;
  logic        en;

  logic [S_OUT:0] vld_q;
  logic [S_OUT:0] oor_q;
  logic [27:0]    t0_q;
  logic [55:0]    tsq0;

  q_t inv_t, inv_t2, inv_t_f, inv_t2_f, lnr_f;
  logic [27:0] t_f;
  q_t tq_f, t2_f;

  q_t tq_b, dt_b, dt2_b, dit_b, dit2_b, lnr_b, inv_t2_b;
  q_t m1, m2, m3, m4, m5, m6, m7, m8, m9;
  q_t i1a_d, i2a_d, gfa_d, cpa_d, m3_d, m6_d, m9_d;
  q_t i1_e, i2_e, cp_e, gfa_e;
  q_t h_f, s_f, g1_f, i2_f, tq_g0;
  q_t p1, p2, h_g, s_g, g1_g, cp_g;
  q_t g_h, h_h, s_h, hel_h, cp_h;
  q_t g_o, h_o, s_o, hel_o, cp_o;

  // configuration
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gf_q <= '0; hf_q <= '0; sr_q <= '0;
      a_q <= '0; b_q <= '0; c_q <= '0;
      tmax_q <= '0;
    end else if (wr) begin
      case (paddr[5:3])
        REG_GF:   gf_q <= pwdata;
        REG_HF:   hf_q <= pwdata;
        REG_SR:   sr_q <= pwdata;
        REG_A:    a_q <= pwdata;
        REG_B:    b_q <= pwdata;
        REG_C:    c_q <= pwdata;
        REG_TMAX: tmax_q <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_GF:   prdata = gf_q;
      REG_HF:   prdata = hf_q;
      REG_SR:   prdata = sr_q;
      REG_A:    prdata = a_q;
      REG_B:    prdata = b_q;
      REG_C:    prdata = c_q;
      REG_TMAX: prdata = {36'd0, tmax_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    hb_q <= half_q(b_q);
    hc_q <= half_q(c_q);
  end

  // flow control
  assign m_tvalid = vld_q[S_OUT];
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[S_OUT-1:0], s_tvalid};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q  <= s_tdata[27:0];
      oor_q <= {oor_q[S_OUT-1:0],
                (s_tdata[27:0] == 28'd0) || (s_tdata[27:0] > tmax_q)};
    end
  end

  // front: reciprocals and log
  assign tsq0 = {28'd0, t0_q} * {28'd0, t0_q};

  gstp_recip u_rcp_t  (.clk_i, .en_i(en), .d_i({20'd0, t0_q, 16'd0}), .q_o(inv_t));
  gstp_recip u_rcp_t2 (.clk_i, .en_i(en), .d_i({8'd0, tsq0}), .q_o(inv_t2));
  gstp_log   u_log    (.clk_i, .en_i(en), .t_i(t0_q), .lnr_o(lnr_f));

  gstp_delay #(.W(64), .D(L_FRONT - L_RCP)) u_dl_it
    (.clk_i, .en_i(en), .d_i(inv_t), .q_o(inv_t_f));
  gstp_delay #(.W(64), .D(L_FRONT - L_RCP)) u_dl_it2
    (.clk_i, .en_i(en), .d_i(inv_t2), .q_o(inv_t2_f));
  gstp_delay #(.W(28), .D(L_FRONT)) u_dl_t
    (.clk_i, .en_i(en), .d_i(t0_q), .q_o(t_f));

  assign tq_f = {20'd0, t_f, 16'd0};
  assign t2_f = {8'd0, {28'd0, t_f} * {28'd0, t_f}};

  // differences
  always_ff @(posedge clk_i) begin
    if (en) begin
      tq_b     <= tq_f;
      dt_b     <= qsub(tq_f, Q_TR);
      dt2_b    <= qsub(t2_f, TR2);
      dit_b    <= qsub(inv_t_f, INV_TR);
      dit2_b   <= qsub(inv_t2_f, INV_TR2);
      lnr_b    <= lnr_f;
      inv_t2_b <= inv_t2_f;
    end
  end

  gstp_qmul u_m1 (.clk_i, .en_i(en), .a_i(a_q),  .b_i(dt_b),     .q_o(m1));
  gstp_qmul u_m2 (.clk_i, .en_i(en), .a_i(hb_q), .b_i(dt2_b),    .q_o(m2));
  gstp_qmul u_m3 (.clk_i, .en_i(en), .a_i(c_q),  .b_i(dit_b),    .q_o(m3));
  gstp_qmul u_m4 (.clk_i, .en_i(en), .a_i(a_q),  .b_i(lnr_b),    .q_o(m4));
  gstp_qmul u_m5 (.clk_i, .en_i(en), .a_i(b_q),  .b_i(dt_b),     .q_o(m5));
  gstp_qmul u_m6 (.clk_i, .en_i(en), .a_i(hc_q), .b_i(dit2_b),   .q_o(m6));
  gstp_qmul u_m7 (.clk_i, .en_i(en), .a_i(sr_q), .b_i(dt_b),     .q_o(m7));
  gstp_qmul u_m8 (.clk_i, .en_i(en), .a_i(b_q),  .b_i(tq_b),     .q_o(m8));
  gstp_qmul u_m9 (.clk_i, .en_i(en), .a_i(c_q),  .b_i(inv_t2_b), .q_o(m9));

  // integrals and sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      i1a_d <= qadd(m1, m2);
      i2a_d <= qadd(m4, m5);
      gfa_d <= qsub(gf_q, m7);
      cpa_d <= qadd(a_q, m8);
      m3_d  <= m3;
      m6_d  <= m6;
      m9_d  <= m9;
      i1_e  <= qsub(i1a_d, m3_d);
      i2_e  <= qsub(i2a_d, m6_d);
      cp_e  <= qadd(cpa_d, m9_d);
      gfa_e <= gfa_d;
      h_f   <= qadd(hf_q, i1_e);
      s_f   <= qadd(sr_q, i2_e);
      g1_f  <= qadd(gfa_e, i1_e);
      i2_f  <= i2_e;
    end
  end

  gstp_delay #(.W(64), .D(S_F - S_B)) u_dl_tq
    (.clk_i, .en_i(en), .d_i(tq_b), .q_o(tq_g0));

  gstp_qmul u_p1 (.clk_i, .en_i(en), .a_i(tq_g0), .b_i(i2_f), .q_o(p1));
  gstp_qmul u_p2 (.clk_i, .en_i(en), .a_i(tq_g0), .b_i(s_f),  .q_o(p2));

  gstp_delay #(.W(64), .D(L_MUL)) u_dl_h
    (.clk_i, .en_i(en), .d_i(h_f), .q_o(h_g));
  gstp_delay #(.W(64), .D(L_MUL)) u_dl_s
    (.clk_i, .en_i(en), .d_i(s_f), .q_o(s_g));
  gstp_delay #(.W(64), .D(L_MUL)) u_dl_g1
    (.clk_i, .en_i(en), .d_i(g1_f), .q_o(g1_g));
  gstp_delay #(.W(64), .D(S_G - S_E)) u_dl_cp
    (.clk_i, .en_i(en), .d_i(cp_e), .q_o(cp_g));

  // final differences; zero the fields of an out-of-range item
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (oor_q[S_G]) begin
        g_h <= '0; h_h <= '0; s_h <= '0; hel_h <= '0; cp_h <= '0;
      end else begin
        g_h   <= qsub(g1_g, p1);
        h_h   <= h_g;
        s_h   <= s_g;
        hel_h <= qsub(h_g, p2);
        cp_h  <= cp_g;
      end
    end
  end

  gstp_qmul u_cg (.clk_i, .en_i(en), .a_i(g_h),   .b_i(Q_CAL), .q_o(g_o));
  gstp_qmul u_ch (.clk_i, .en_i(en), .a_i(h_h),   .b_i(Q_CAL), .q_o(h_o));
  gstp_qmul u_cs (.clk_i, .en_i(en), .a_i(s_h),   .b_i(Q_CAL), .q_o(s_o));
  gstp_qmul u_ca (.clk_i, .en_i(en), .a_i(hel_h), .b_i(Q_CAL), .q_o(hel_o));
  gstp_qmul u_cc (.clk_i, .en_i(en), .a_i(cp_h),  .b_i(Q_CAL), .q_o(cp_o));

  assign m_tdata = {cp_o, hel_o, h_o, s_o, h_o, g_o};
  assign m_tuser = oor_q[S_OUT];

endmodule
